// File: rtl/core/lfowg_pkg.sv
// Shared constants and types for the LFO waveform generator.
// No dependencies; imported by lfo_waveform_generator_unit.
package lfowg_pkg;

    localparam int unsigned PHASE_WIDTH_DEF = 32;
    localparam int unsigned SINE_DEPTH_DEF  = 256;

    localparam logic [31:0] LFSR_SEED        = 32'hB5AD4ECE;
    localparam logic [31:0] LFSR_MASK        = 32'h80200003;
    localparam logic [47:0] STEP_SCALE_RESET = 48'd3843071682023;
    localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;

    // register index is address bit 3 (64-bit registers at 8-byte spacing)
    localparam logic REG_WAVEFORM   = 1'b0;
    localparam logic REG_STEP_SCALE = 1'b1;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SAWTOOTH = 3'd2,
        WAVE_SQUARE   = 3'd3,
        WAVE_RANDOM   = 3'd4,
        WAVE_HOLD     = 3'd5
    } t_waveform;

endpackage

// File: rtl/core/lfo_waveform_generator_unit.sv
// LFO waveform generator top level: input, product, waveform and output stages.
// Each accepted request is registered in the input, product, waveform and output stages in turn.
// Throughput: one request per cycle while the output is not stalled; the phase add
// and registered sine ROM read close in the waveform stage for each item.
// Reset: synchronous, active low; clears phase, held value, LFSR (to seed),
// pipeline valids; sets the configuration registers to their reset values. Depends on lfowg_pkg.
module lfo_waveform_generator_unit #(
    parameter int unsigned SINE_TABLE_DEPTH = lfowg_pkg::SINE_DEPTH_DEF,
    parameter int unsigned PHASE_WIDTH      = lfowg_pkg::PHASE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [20:0]        i_rate_centihz,
    input  logic [15:0]        i_depth,
    input  logic signed [15:0] i_sample_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_wave_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import lfowg_pkg::*;

    localparam int unsigned FracW = PHASE_WIDTH - 2;
    localparam int unsigned IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int unsigned ProdW = FracW + IdxW;

    function automatic logic [14:0] f_quarter_sine(input longint unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = HALF_PI_Q30 * i / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 156;
        sum  = sum + term;
        v    = (sum * 32767 + (64'd1 << 29)) >> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return 15'(v);
    endfunction

    // quarter-wave ROM
    logic [14:0] w_rom [0:SINE_TABLE_DEPTH];
    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        assign w_rom[g] = f_quarter_sine(longint'(g));
    end

    // configuration
    t_waveform   r_waveform;
    logic [47:0] r_step_scale;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform   <= WAVE_SINE;
            r_step_scale <= STEP_SCALE_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[3])
                REG_WAVEFORM:   r_waveform   <= t_waveform'(pwdata[2:0]);
                REG_STEP_SCALE: r_step_scale <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_WAVEFORM:   prdata = {61'b0, r_waveform};
            REG_STEP_SCALE: prdata = {16'b0, r_step_scale};
            default:        prdata = '0;
        endcase
    end

    // pipeline flow
    logic r_a_valid, r_b_valid, r_c_valid, r_out_valid;
    logic w_out_free, w_c_free, w_b_free, w_a_free;
    logic w_c_move, w_b_move;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_c_free   = !r_c_valid || w_out_free;
    assign w_b_free   = !r_b_valid || w_c_free;
    assign w_a_free   = !r_a_valid || w_b_free;
    assign w_c_move   = r_c_valid && w_out_free;
    assign w_b_move   = r_b_valid && w_c_free;
    assign o_in_ready = w_a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_a_free)   r_a_valid   <= i_in_valid;
            if (w_b_free)   r_b_valid   <= r_a_valid;
            if (w_c_free)   r_c_valid   <= r_b_valid;
            if (w_out_free) r_out_valid <= r_c_valid;
        end
    end

    // stage A: input register
    logic [20:0]        r_a_rate;
    logic [15:0]        r_a_depth;
    logic signed [15:0] r_a_sample;

    always_ff @(posedge i_clk) begin
        if (w_a_free && i_in_valid) begin
            r_a_rate   <= i_rate_centihz;
            r_a_depth  <= i_depth;
            r_a_sample <= i_sample_in;
        end
    end

    // stage B: partial products of rate * step_scale (mod 2^64)
    logic [52:0]        r_b_plo;
    logic [31:0]        r_b_phi;
    logic [15:0]        r_b_depth;
    logic signed [15:0] r_b_sample;
    logic [36:0]        w_phi;

    assign w_phi = 37'(r_a_rate) * 37'(r_step_scale[47:32]);

    always_ff @(posedge i_clk) begin
        if (w_b_free && r_a_valid) begin
            r_b_plo    <= 53'(r_a_rate) * 53'(r_step_scale[31:0]);
            r_b_phi    <= w_phi[31:0];
            r_b_depth  <= r_a_depth;
            r_b_sample <= r_a_sample;
        end
    end

    // waveform stage: state update and depth product
    logic [PHASE_WIDTH-1:0] r_phase, n_phase;
    logic signed [15:0]     r_held, n_held;
    logic                   r_flag, n_flag;
    logic [1:0]             r_quad, n_quad;
    logic [31:0]            r_lfsr, n_lfsr, w_lfsr_step;
    logic [14:0]            r_sine_mag;
    logic [63:0]            w_full;
    logic [ProdW-1:0]       w_idx_prod;
    logic [IdxW-1:0]        w_idx_raw, n_idx;
    logic signed [15:0]     w_t, w_sine, w_saw, w_tri16;
    logic signed [17:0]     w_t18, w_tri;
    logic                   w_positive;
    logic signed [32:0]     w_v33, w_d33;

    assign w_full  = {r_b_phi, 32'b0} + {11'b0, r_b_plo};
    assign n_phase = r_phase + w_full[63 -: PHASE_WIDTH];

    // sine magnitude register is loaded with the phase register, from the same next phase
    assign w_idx_prod = ProdW'(n_phase[FracW-1:0]) * ProdW'(SINE_TABLE_DEPTH);
    assign w_idx_raw  = w_idx_prod[ProdW-1:FracW];
    assign n_idx      = n_phase[PHASE_WIDTH-2] ? IdxW'(SINE_TABLE_DEPTH) - w_idx_raw
                                               : w_idx_raw;

    assign w_t        = signed'(r_phase[PHASE_WIDTH-1 -: 16]);
    assign w_t18      = 18'(w_t);
    assign w_tri      = (w_t18 > 18'sd0) ? (w_t18 + w_t18 - 18'sd32768)
                                         : (-18'sd32768 - w_t18 - w_t18);
    assign w_tri16    = (w_tri > 18'sd32767) ? 16'sh7FFF : w_tri[15:0];
    assign w_saw      = w_t >>> 1;
    assign w_sine     = r_phase[PHASE_WIDTH-1] ? -signed'({1'b0, r_sine_mag})
                                               : signed'({1'b0, r_sine_mag});
    assign w_positive = (r_phase != '0) && !r_phase[PHASE_WIDTH-1];
    assign w_lfsr_step = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_MASK) : (r_lfsr >> 1);

    always_comb begin
        n_held = r_held;
        n_lfsr = r_lfsr;
        n_flag = r_flag;
        n_quad = r_quad;
        case (r_waveform)
            WAVE_SINE:     n_held = w_sine;
            WAVE_TRIANGLE: n_held = w_tri16;
            WAVE_SAWTOOTH: n_held = w_saw;
            WAVE_SQUARE:   n_held = w_positive ? 16'sh7FFF : -16'sh8000;
            WAVE_RANDOM: begin
                if (r_flag) begin
                    n_lfsr = w_lfsr_step;
                    n_held = signed'(w_lfsr_step[31:16]);
                end
            end
            WAVE_HOLD: begin
                if (r_flag) n_held = r_b_sample;
            end
            default: ;
        endcase
        if (r_waveform == WAVE_RANDOM || r_waveform == WAVE_HOLD) begin
            n_quad = n_phase[PHASE_WIDTH-1 -: 2];
            n_flag = (n_quad != r_quad);
        end
    end

    assign w_v33 = 33'(n_held);
    assign w_d33 = signed'(33'(r_b_depth));

    logic signed [32:0] r_c_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_held     <= '0;
            r_flag     <= 1'b0;
            r_quad     <= '0;
            r_lfsr     <= LFSR_SEED;
            r_sine_mag <= '0;
        end else if (w_b_move) begin
            r_phase    <= n_phase;
            r_held     <= n_held;
            r_flag     <= n_flag;
            r_quad     <= n_quad;
            r_lfsr     <= n_lfsr;
            r_sine_mag <= w_rom[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_move) begin
            r_c_prod <= w_v33 * w_d33;
        end
    end

    // output stage: round half up and saturate
    logic signed [34:0] w_round;
    logic signed [15:0] r_out_wave;

    assign w_round = (35'(r_c_prod) + 35'sd16384) >>> 15;

    always_ff @(posedge i_clk) begin
        if (w_c_move) begin
            if (w_round > 35'sd32767) begin
                r_out_wave <= 16'sh7FFF;
            end else if (w_round < -35'sd32768) begin
                r_out_wave <= -16'sh8000;
            end else begin
                r_out_wave <= w_round[15:0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_wave_out  = r_out_wave;

    // checks
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_a_valid)
        else $error("accepted request not captured in input stage");

    a_phase_moves_on_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_phase)) |-> $past(w_b_move))
        else $error("phase changed without an item in the waveform stage");

    a_flag_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_flag)) |->
        ($past(r_waveform) == WAVE_RANDOM || $past(r_waveform) == WAVE_HOLD))
        else $error("resample flag changed outside random or hold mode");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_lfsr != '0))
        else $error("noise LFSR reached the all-zero state");

endmodule
